// ----- hw/rtl/md5bc_pkg.sv -----
// md5bc_pkg: shared types, constants and table functions for the md5 block
// compression core (word structs, controller command/status, step tables)
// no dependencies
`timescale 1ns / 1ps

package md5bc_pkg;

  // standard md5 initial chaining words
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned NUM_STEPS   = 64;

  // input word
  typedef struct packed {
    logic [31:0] message_word;
    logic        restart;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;
  } out_word_t;

  // controller states
  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_ROUND = 3'b010,
    ST_FINAL = 3'b100
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       wr_word;
    logic [3:0] wr_addr;
    logic       reload_iv;
    logic       start;
    logic       step;
    logic [5:0] step_idx;
    logic       finish;
  } ctrl_cmd_t;

  // controller status seen at the top level
  typedef struct packed {
    state_t     state;
    logic [3:0] word_count;
  } ctrl_stat_t;

  // sine-derived step constants
  function automatic logic [31:0] step_const(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // left rotate amount, indexed by {round, step within group of four}
  function automatic logic [4:0] rot_amount(input logic [3:0] idx);
    logic [4:0] s;
    unique case (idx)
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

endpackage

// ----- hw/rtl/md5bc_ctrl.sv -----
// md5bc_ctrl: sequencer for the md5 block compression core
// counts buffered words, steps the 64 steps of the four rounds and hands off the result word
// depends on md5bc_pkg
`timescale 1ns / 1ps

module md5bc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_restart,
  output logic                  in_ready,
  input  logic                  out_ready,
  output logic                  out_valid,
  output md5bc_pkg::ctrl_cmd_t  cmd,
  output md5bc_pkg::ctrl_stat_t stat
);

  md5bc_pkg::state_t state_r, state_nxt;
  logic [3:0] count_r, count_nxt;
  logic [5:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic [3:0] wr_addr;
  logic       out_free;

  assign in_ready = (state_r == md5bc_pkg::ST_LOAD);
  assign accept   = in_valid && in_ready;
  assign wr_addr  = in_restart ? 4'd0 : count_r;
  assign out_free = !out_valid_r || out_ready;

  // next state and counters
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      md5bc_pkg::ST_LOAD: begin
        if (accept) begin
          count_nxt = wr_addr + 4'd1;
          if (wr_addr == 4'(md5bc_pkg::BLOCK_WORDS - 1)) begin
            state_nxt = md5bc_pkg::ST_ROUND;
            step_nxt  = 6'd0;
          end
        end
      end
      md5bc_pkg::ST_ROUND: begin
        step_nxt = step_r + 6'd1;
        if (step_r == 6'(md5bc_pkg::NUM_STEPS - 1)) begin
          state_nxt = md5bc_pkg::ST_FINAL;
        end
      end
      md5bc_pkg::ST_FINAL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = md5bc_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = md5bc_pkg::ST_LOAD;
      end
    endcase
  end

  // command decode
  always_comb begin
    cmd           = '0;
    cmd.wr_word   = accept;
    cmd.wr_addr   = wr_addr;
    cmd.reload_iv = accept && in_restart;
    cmd.start     = accept && (wr_addr == 4'(md5bc_pkg::BLOCK_WORDS - 1));
    cmd.step      = (state_r == md5bc_pkg::ST_ROUND);
    cmd.step_idx  = step_r;
    cmd.finish    = (state_r == md5bc_pkg::ST_FINAL) && out_free;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= md5bc_pkg::ST_LOAD;
      count_r     <= 4'd0;
      step_r      <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign stat.state      = state_r;
  assign stat.word_count = count_r;

endmodule

// ----- hw/rtl/md5bc_datapath.sv -----
// md5bc_datapath: word buffer, chaining value, working registers and
// one md5 step per cycle, plus the result register
// depends on md5bc_pkg
`timescale 1ns / 1ps

module md5bc_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  md5bc_pkg::ctrl_cmd_t cmd,
  input  logic [31:0]          in_word,
  output md5bc_pkg::out_word_t out_data
);

  logic [31:0] blk_r [md5bc_pkg::BLOCK_WORDS];
  logic [31:0] cv_a_r, cv_b_r, cv_c_r, cv_d_r;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt;
  md5bc_pkg::out_word_t out_r;

  logic [1:0]  rnd;
  logic [3:0]  i4;
  logic [3:0]  g;
  logic [31:0] f;
  logic [31:0] sum;
  logic [4:0]  sh;
  logic [63:0] rot_wide;
  logic [31:0] rot;

  assign rnd = cmd.step_idx[5:4];
  assign i4  = cmd.step_idx[3:0];

  // round function and message index
  always_comb begin
    unique case (rnd)
      2'd0: begin
        f = (b_r & c_r) | (~b_r & d_r);
        g = i4;
      end
      2'd1: begin
        f = (d_r & b_r) | (~d_r & c_r);
        g = 4'((i4 << 2) + i4 + 4'd1);
      end
      2'd2: begin
        f = b_r ^ c_r ^ d_r;
        g = 4'((i4 << 1) + i4 + 4'd5);
      end
      default: begin
        f = c_r ^ (b_r | ~d_r);
        g = 4'((i4 << 3) - i4);
      end
    endcase
  end

  // step sum and rotate
  assign sum      = a_r + f + md5bc_pkg::step_const(cmd.step_idx) + blk_r[g];
  assign sh       = md5bc_pkg::rot_amount({rnd, i4[1:0]});
  assign rot_wide = {sum, sum} << sh;
  assign rot      = rot_wide[63:32];

  // working register update
  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    d_nxt = d_r;
    if (cmd.start) begin
      a_nxt = cv_a_r;
      b_nxt = cv_b_r;
      c_nxt = cv_c_r;
      d_nxt = cv_d_r;
    end else if (cmd.step) begin
      a_nxt = d_r;
      b_nxt = b_r + rot;
      c_nxt = b_r;
      d_nxt = c_r;
    end
  end

  // word buffer, no reset
  always_ff @(posedge clk) begin
    if (cmd.wr_word) begin
      blk_r[cmd.wr_addr] <= in_word;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
  end

  // chaining value: iv at reset and restart, feed-forward add at finish
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reload_iv) begin
      cv_a_r <= md5bc_pkg::IV_A;
      cv_b_r <= md5bc_pkg::IV_B;
      cv_c_r <= md5bc_pkg::IV_C;
      cv_d_r <= md5bc_pkg::IV_D;
    end else if (cmd.finish) begin
      cv_a_r <= cv_a_r + a_r;
      cv_b_r <= cv_b_r + b_r;
      cv_c_r <= cv_c_r + c_r;
      cv_d_r <= cv_d_r + d_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.digest_a <= cv_a_r + a_r;
      out_r.digest_b <= cv_b_r + b_r;
      out_r.digest_c <= cv_c_r + c_r;
      out_r.digest_d <= cv_d_r + d_r;
    end
  end

  assign out_data = out_r;

endmodule

// ----- hw/rtl/md5_block_compression.sv -----
// md5_block_compression: md5 compression core, 16 words in, digest word out
// the sixteenth word starts the 64 steps in the single round unit (ROUND state),
// then one final add (FINAL state) raises out_valid; one word a cycle is taken
// while buffering, none while the steps or the final add run; a result held by
// out_ready low stalls the final add of the next block
// reset (synchronous, rst_n low) loads the initial chaining value and clears
// the word count; the word buffer is not reset
`timescale 1ns / 1ps

module md5_block_compression (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  md5bc_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output md5bc_pkg::out_word_t out_data
);

  md5bc_pkg::ctrl_cmd_t  cmd;
  md5bc_pkg::ctrl_stat_t stat;

  // sequencer
  md5bc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_data.restart),
    .in_ready   (in_ready),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .cmd        (cmd),
    .stat       (stat)
  );

  // datapath
  md5bc_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_data.message_word),
    .out_data (out_data)
  );

  // controller state stays one-hot
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(stat.state))
    else $error("controller state not one-hot");

  // a word with restart becomes word 0 of a new block
  a_restart_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.restart) |=> (stat.word_count == 4'd1))
    else $error("restart word did not start a fresh block");

  // no word taken while the rounds run
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !in_ready)
    else $error("input accepted during rounds");

  // finishing a block always presents a result
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("finished block gave no result");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");

endmodule

// ----- test/tb.sv -----
// tb: self-checking bench for md5_block_compression, words in, chaining value out
// depends on md5bc_pkg (word structs, initial chaining words) and the core rtl
`timescale 1ns / 1ps

module tb;

  localparam int unsigned WORD_GOAL   = 2040;
  localparam int unsigned IDLE_LIMIT  = 5000;
  localparam int unsigned HOLD_CYCLES = 400;

  // per-step left rotation, index {round, step mod 4}
  localparam logic [15:0][4:0] ROT_AMT = {
    5'd21, 5'd15, 5'd10, 5'd6,
    5'd23, 5'd16, 5'd11, 5'd4,
    5'd20, 5'd14, 5'd9,  5'd5,
    5'd22, 5'd17, 5'd12, 5'd7
  };

  typedef struct {
    logic [31:0]          word;
    logic                 restart;
    int unsigned          count;
    logic                 known;
    md5bc_pkg::out_word_t digest;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  md5bc_pkg::in_word_t  in_data;
  logic                 out_valid;
  logic                 out_ready;
  md5bc_pkg::out_word_t out_data;

  // golden md5 state
  logic [31:0] chain_q [4];
  logic [31:0] block_q [16];
  int unsigned fill_cnt;
  logic [31:0] sine_k [64];

  md5bc_pkg::out_word_t pending_digests [$];
  dir_row_t             dir_rows [$];
  int unsigned          words_taken;
  int unsigned          fault_count;
  int unsigned          stuck_cycles;

  md5_block_compression uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sine-derived step constants, floor(abs(sin(i + 1)) * 2^32)
  initial begin : sine_fill
    real    r;
    longint v;
    for (int i = 0; i < 64; i++) begin
      r = $sin(i + 1);
      if (r < 0.0) r = -r;
      v = longint'($floor(r * 4294967296.0));
      sine_k[i] = v[31:0];
    end
  end

  function automatic bit quiet_phase();
    return (words_taken >= 1300) && (words_taken < 1600);
  endfunction

  task automatic report_fault(input string msg);
    fault_count++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_fault($sformatf("%s got %h want %h", name, got, want));
  endtask

  // 64 md5 steps on the buffered block, folded into the chaining value
  task automatic md5_compress();
    logic [31:0] a, b, c, d, f, sum, tmp;
    int          g, rnd, sh;
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    for (int i = 0; i < 64; i++) begin
      rnd = i / 16;
      case (rnd)
        0: begin
          f = (b & c) | (~b & d);
          g = i % 16;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      sum = a + f + sine_k[i] + block_q[g];
      sh  = ROT_AMT[rnd * 4 + i % 4];
      tmp = d;
      d   = c;
      c   = b;
      b   = b + ((sum << sh) | (sum >> (32 - sh)));
      a   = tmp;
    end
    chain_q[0] = chain_q[0] + a;
    chain_q[1] = chain_q[1] + b;
    chain_q[2] = chain_q[2] + c;
    chain_q[3] = chain_q[3] + d;
  endtask

  // buffer one word; a full block yields the new chaining value
  task automatic md5_absorb(input md5bc_pkg::in_word_t w, output logic done,
                            output md5bc_pkg::out_word_t digest);
    if (w.restart) begin
      chain_q[0] = md5bc_pkg::IV_A;
      chain_q[1] = md5bc_pkg::IV_B;
      chain_q[2] = md5bc_pkg::IV_C;
      chain_q[3] = md5bc_pkg::IV_D;
      fill_cnt   = 0;
    end
    block_q[fill_cnt] = w.message_word;
    fill_cnt = (fill_cnt + 1) % 16;
    done = (fill_cnt == 0);
    if (done) md5_compress();
    digest.digest_a = chain_q[0];
    digest.digest_b = chain_q[1];
    digest.digest_c = chain_q[2];
    digest.digest_d = chain_q[3];
  endtask

  // offer one word, with random idle cycles ahead of it outside the quiet phase
  task automatic send_word(input logic [31:0] w, input logic rs, input logic typed,
                           input md5bc_pkg::out_word_t typed_digest);
    md5bc_pkg::in_word_t  item;
    logic                 done;
    md5bc_pkg::out_word_t digest;
    bit                   idled;
    idled = 1'b0;
    while (!quiet_phase() && $urandom_range(99) < 36) begin
      if (!idled) in_valid <= 1'b0;
      idled = 1'b1;
      @(posedge clk);
    end
    item.message_word = w;
    item.restart      = rs;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_taken++;
    md5_absorb(item, done, digest);
    if (done) pending_digests.push_back(typed ? typed_digest : digest);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(input logic [31:0] w, input logic rs, input int unsigned n,
                         input logic known, input logic [31:0] da, input logic [31:0] db,
                         input logic [31:0] dc, input logic [31:0] dd);
    dir_row_t row;
    row.word            = w;
    row.restart         = rs;
    row.count           = n;
    row.known           = known;
    row.digest.digest_a = da;
    row.digest.digest_b = db;
    row.digest.digest_c = dc;
    row.digest.digest_d = dd;
    dir_rows.push_back(row);
  endtask

  // stall watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= IDLE_LIMIT) begin
      $display("[md5_block_compression] ERROR");
      $finish;
    end
  end

  // result side: random backpressure, one long hold-off, digest compare
  initial begin : digest_sink
    md5bc_pkg::out_word_t want;
    int unsigned          hold_left;
    bit                   held;
    logic                 rdy;
    hold_left = 0;
    held      = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_digests.size() == 0) begin
          report_fault($sformatf("digest %h with none expected", out_data));
        end else begin
          want = pending_digests.pop_front();
          check_field("digest_a", out_data.digest_a, want.digest_a);
          check_field("digest_b", out_data.digest_b, want.digest_b);
          check_field("digest_c", out_data.digest_c, want.digest_c);
          check_field("digest_d", out_data.digest_d, want.digest_d);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!held && words_taken >= 500) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
        rdy       = 1'b0;
      end else if (quiet_phase()) begin
        rdy = 1'b1;
      end else begin
        rdy = ($urandom_range(99) >= 36);
      end
      out_ready <= rdy;
    end
  end

  // word source: directed table, then random messages
  initial begin : word_source
    bit          drained;
    bit          force_restart;
    bit          fresh;
    int unsigned n_blocks;
    int unsigned kind;
    int unsigned n;
    chain_q[0]  = md5bc_pkg::IV_A;
    chain_q[1]  = md5bc_pkg::IV_B;
    chain_q[2]  = md5bc_pkg::IV_C;
    chain_q[3]  = md5bc_pkg::IV_D;
    fill_cnt    = 0;
    words_taken = 0;
    drained       = 1'b0;
    force_restart = 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    rst_n    <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // "abc" padded, no restart flag right after reset
    add_row(32'h8063_6261, 1'b0, 1,  1'b0, '0, '0, '0, '0);
    add_row(32'h0000_0000, 1'b0, 13, 1'b0, '0, '0, '0, '0);
    add_row(32'h0000_0018, 1'b0, 1,  1'b0, '0, '0, '0, '0);
    add_row(32'h0000_0000, 1'b0, 1,  1'b1,
            32'h9850_0190, 32'hb04f_d23c, 32'h7d3f_96d6, 32'h727f_e128);
    // partial block of all-ones words, dropped by a restart
    add_row(32'hffff_ffff, 1'b1, 1,  1'b0, '0, '0, '0, '0);
    add_row(32'hffff_ffff, 1'b0, 1,  1'b0, '0, '0, '0, '0);
    // empty message padded, flagged as a fresh message mid-block
    add_row(32'h0000_0080, 1'b1, 1,  1'b0, '0, '0, '0, '0);
    add_row(32'h0000_0000, 1'b0, 14, 1'b0, '0, '0, '0, '0);
    add_row(32'h0000_0000, 1'b0, 1,  1'b1,
            32'hd98c_1dd4, 32'h04b2_008f, 32'h9809_80e9, 32'h7e42_f8ec);
    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].count; k++)
        send_word(dir_rows[r].word, dir_rows[r].restart,
                  dir_rows[r].known && (k == dir_rows[r].count - 1), dir_rows[r].digest);
    end

    // random messages of one to four blocks, some broken or noisy
    while (words_taken < WORD_GOAL) begin
      if (!drained && words_taken >= 1000) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_digests.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
      n_blocks      = $urandom_range(1, 4);
      fresh         = force_restart || ($urandom_range(9) != 0);
      force_restart = 1'b0;
      for (int blk = 0; blk < n_blocks; blk++) begin
        kind = $urandom_range(99);
        if (kind < 8) begin
          // truncated block, next message must restart
          n = $urandom_range(1, 15);
          for (int i = 0; i < n; i++)
            send_word(pick_word(), fresh && blk == 0 && i == 0, 1'b0, '0);
          force_restart = 1'b1;
          break;
        end else if (kind < 13) begin
          // restart flags sprinkled at random
          for (int i = 0; i < 16; i++)
            send_word(pick_word(), $urandom_range(7) == 0, 1'b0, '0);
          force_restart = 1'b1;
          break;
        end else begin
          for (int i = 0; i < 16; i++)
            send_word(pick_word(), fresh && blk == 0 && i == 0, 1'b0, '0);
        end
      end
    end

    // drain and let the core settle
    in_valid <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fault_count == 0) begin
      $display("[md5_block_compression] OK");
    end else begin
      $display("[md5_block_compression] ERROR");
    end
    $finish;
  end

endmodule
